FILE: design/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometric temperature/pressure
// compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // pipelined divider geometry
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_BITS;

  // configuration register indexes
  localparam logic [2:0] REG_AC1   = 3'd0;
  localparam logic [2:0] REG_AC2   = 3'd1;
  localparam logic [2:0] REG_AC3   = 3'd2;
  localparam logic [2:0] REG_AC4   = 3'd3;
  localparam logic [2:0] REG_AC5   = 3'd4;
  localparam logic [2:0] REG_AC6   = 3'd5;
  localparam logic [2:0] REG_B1_B2 = 3'd6;
  localparam logic [2:0] REG_MC_MD = 3'd7;

  // algorithm constants
  localparam logic [31:0] T_ROUND    = 32'd8;
  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] B3_ROUND   = 32'd2;
  localparam logic [31:0] B4_OFFSET  = 32'd32768;
  localparam int unsigned B7_BASE    = 50000;
  localparam logic [31:0] P_C1       = 32'd3038;
  localparam logic [31:0] P_C2       = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_C3       = 32'd3791;
  localparam logic [31:0] P_ZERO_LO  = 32'hFFFF_FFFF;
  localparam logic [31:0] P_ZERO_HI  = 32'hFFFF_FFFE;

  // side data carried through the temperature divider
  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        neg;
    logic        zero;
  } tdiv_side_t;

  // side data carried through the pressure divider
  typedef struct packed {
    logic [31:0] t;
    logic        fault;
    logic        hi;
    logic        zero;
  } pdiv_side_t;

endpackage

FILE: design/baro_temp_pressure_compensate.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensate
// Integer temperature and pressure compensation from ten calibration
// coefficients, as a fully pipelined datapath with two pipelined dividers.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while not stalled; set by the 16-stage dividers, which
//   take two quotient bits per stage, and by a pipeline-wide advance enable.
// The whole pipeline holds while the output is valid and stalled.
// Reset empties the pipeline and loads the coefficient registers with their
//   factory defaults.
module baro_temp_pressure_compensate
  import bptc_pkg::*;
#(
  parameter int unsigned OVERSAMPLING = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        raw_temperature,
  input  logic [18:0]        raw_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] temperature_tenths,
  output logic signed [31:0] pressure_pa,
  output logic               divide_fault
);

  localparam int unsigned OSS    = OVERSAMPLING % 4;
  localparam logic [31:0] B7_MUL = 32'(B7_BASE >> OSS);

  // ---------------------------------------------------------------- config
  logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
  logic [31:0] b1_b2, mc_md;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1   <= 16'd408;
      ac2   <= 16'hFFB8;
      ac3   <= 16'hC7D1;
      ac4   <= 16'd32741;
      ac5   <= 16'd32757;
      ac6   <= 16'd23153;
      b1_b2 <= 32'd405667844;
      mc_md <= 32'd3724086068;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AC1:   ac1   <= cfg_wdata[15:0];
        REG_AC2:   ac2   <= cfg_wdata[15:0];
        REG_AC3:   ac3   <= cfg_wdata[15:0];
        REG_AC4:   ac4   <= cfg_wdata[15:0];
        REG_AC5:   ac5   <= cfg_wdata[15:0];
        REG_AC6:   ac6   <= cfg_wdata[15:0];
        REG_B1_B2: b1_b2 <= cfg_wdata;
        REG_MC_MD: mc_md <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [31:0] ac1_x, ac2_x, ac3_x, b1_x, b2_x, md_x;
  assign ac1_x = {{16{ac1[15]}}, ac1};
  assign ac2_x = {{16{ac2[15]}}, ac2};
  assign ac3_x = {{16{ac3[15]}}, ac3};
  assign b1_x  = {{16{b1_b2[31]}}, b1_b2[31:16]};
  assign b2_x  = {{16{b1_b2[15]}}, b1_b2[15:0]};
  assign md_x  = {{16{mc_md[15]}}, mc_md[15:0]};

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------- s1: capture
  logic        s1_v;
  logic [15:0] s1_ut;
  logic [18:0] s1_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v  <= in_valid;
      s1_ut <= raw_temperature;
      s1_up <= raw_pressure;
    end
  end

  // -------------------------------------------------------------- s2: x1
  logic signed [17:0] s2_diff;
  logic signed [34:0] s2_prod;
  logic               s2_v;
  logic [31:0]        s2_x1;
  logic [18:0]        s2_up;

  assign s2_diff = $signed({2'b00, s1_ut}) - $signed({2'b00, ac6});
  assign s2_prod = s2_diff * $signed({1'b0, ac5});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v  <= s1_v;
      s2_x1 <= 32'($signed(s2_prod[31:0]) >>> 15);
      s2_up <= s1_up;
    end
  end

  // ------------------------------------------------- s3: signed div setup
  logic [31:0] s3_den, s3_num, s3_mag_n, s3_mag_d;
  logic        s3_v;
  logic [31:0] s3_n, s3_d;
  tdiv_side_t  s3_side;

  assign s3_den   = s2_x1 + md_x;
  assign s3_num   = {{5{mc_md[31]}}, mc_md[31:16], 11'b0};
  assign s3_mag_n = mc_md[31] ? (32'd0 - s3_num) : s3_num;
  assign s3_mag_d = s3_den[31] ? (32'd0 - s3_den) : s3_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v         <= s2_v;
      s3_n         <= s3_mag_n;
      s3_d         <= s3_mag_d;
      s3_side.x1   <= s2_x1;
      s3_side.up   <= s2_up;
      s3_side.neg  <= mc_md[31] ^ s3_den[31];
      s3_side.zero <= (s3_den == '0);
    end
  end

  logic        td_v;
  logic [31:0] td_q;
  tdiv_side_t  td_side;

  bptc_div #(.SIDE_W($bits(tdiv_side_t))) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s3_v),
    .num       (s3_n),
    .den       (s3_d),
    .side      (s3_side),
    .out_valid (td_v),
    .quo       (td_q),
    .out_side  (td_side)
  );

  // ---------------------------------------------------- s4: b5, t, b6
  logic [31:0] s4_x2, s4_b5, s4_tsum;
  logic        s4_v, s4_fault;
  logic [31:0] s4_t, s4_b6;
  logic [18:0] s4_up;

  always_comb begin
    if (td_side.zero) begin
      s4_x2 = '1;
    end else if (td_side.neg) begin
      s4_x2 = 32'd0 - td_q;
    end else begin
      s4_x2 = td_q;
    end
  end
  assign s4_b5   = td_side.x1 + s4_x2;
  assign s4_tsum = s4_b5 + T_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v     <= td_v;
      s4_t     <= 32'($signed(s4_tsum) >>> 4);
      s4_b6    <= s4_b5 - B6_OFFSET;
      s4_up    <= td_side.up;
      s4_fault <= td_side.zero;
    end
  end

  // -------------------------------------------------------- s5: b6 square
  logic [31:0] s5_sq;
  logic        s5_v, s5_fault;
  logic [31:0] s5_t, s5_b6, s5_b6sq;
  logic [18:0] s5_up;

  assign s5_sq = s4_b6 * s4_b6;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v     <= s4_v;
      s5_b6sq  <= 32'($signed(s5_sq) >>> 12);
      s5_b6    <= s4_b6;
      s5_t     <= s4_t;
      s5_up    <= s4_up;
      s5_fault <= s4_fault;
    end
  end

  // -------------------------------------------------- s6: coefficient mults
  logic [31:0] s6_p1, s6_p2, s6_p3, s6_p4;
  logic        s6_v, s6_fault;
  logic [31:0] s6_m1, s6_m2, s6_m3, s6_m4, s6_t;
  logic [18:0] s6_up;

  assign s6_p1 = b2_x * s5_b6sq;
  assign s6_p2 = ac2_x * s5_b6;
  assign s6_p3 = ac3_x * s5_b6;
  assign s6_p4 = b1_x * s5_b6sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (adv) begin
      s6_v     <= s5_v;
      s6_m1    <= 32'($signed(s6_p1) >>> 11);
      s6_m2    <= 32'($signed(s6_p2) >>> 11);
      s6_m3    <= 32'($signed(s6_p3) >>> 13);
      s6_m4    <= 32'($signed(s6_p4) >>> 16);
      s6_t     <= s5_t;
      s6_up    <= s5_up;
      s6_fault <= s5_fault;
    end
  end

  // ---------------------------------------------------------- s7: b3, x3
  logic [31:0] s7_b3sum, s7_x3sum;
  logic        s7_v, s7_fault;
  logic [31:0] s7_b3, s7_x3, s7_t;
  logic [18:0] s7_up;

  assign s7_b3sum = (((ac1_x << 2) + s6_m1 + s6_m2) << OSS) + B3_ROUND;
  assign s7_x3sum = s6_m3 + s6_m4 + B3_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (adv) begin
      s7_v     <= s6_v;
      s7_b3    <= 32'($signed(s7_b3sum) >>> 2);
      s7_x3    <= 32'($signed(s7_x3sum) >>> 2);
      s7_t     <= s6_t;
      s7_up    <= s6_up;
      s7_fault <= s6_fault;
    end
  end

  // ---------------------------------------------------------- s8: b4, b7
  logic [31:0] s8_b4p, s8_b7p;
  logic        s8_v, s8_fault;
  logic [31:0] s8_b4, s8_b7, s8_t;

  assign s8_b4p = {16'd0, ac4} * (s7_x3 + B4_OFFSET);
  assign s8_b7p = ({13'd0, s7_up} - s7_b3) * B7_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (adv) begin
      s8_v     <= s7_v;
      s8_b4    <= s8_b4p >> 15;
      s8_b7    <= s8_b7p;
      s8_t     <= s7_t;
      s8_fault <= s7_fault;
    end
  end

  // ------------------------------------------------ s9: pressure div setup
  logic        s9_v;
  logic [31:0] s9_n, s9_d;
  pdiv_side_t  s9_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (adv) begin
      s9_v          <= s8_v;
      // scale before dividing when the doubled dividend still fits
      s9_n          <= s8_b7[31] ? s8_b7 : {s8_b7[30:0], 1'b0};
      s9_d          <= s8_b4;
      s9_side.t     <= s8_t;
      s9_side.fault <= s8_fault;
      s9_side.hi    <= s8_b7[31];
      s9_side.zero  <= (s8_b4 == '0);
    end
  end

  logic        pd_v;
  logic [31:0] pd_q;
  pdiv_side_t  pd_side;

  bptc_div #(.SIDE_W($bits(pdiv_side_t))) u_pdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s9_v),
    .num       (s9_n),
    .den       (s9_d),
    .side      (s9_side),
    .out_valid (pd_v),
    .quo       (pd_q),
    .out_side  (pd_side)
  );

  // ------------------------------------------------------------ s10: p
  logic [31:0] s10_pn;
  logic        s10_v, s10_fault;
  logic [31:0] s10_p, s10_t;

  always_comb begin
    if (pd_side.zero) begin
      s10_pn = pd_side.hi ? P_ZERO_HI : P_ZERO_LO;
    end else if (pd_side.hi) begin
      s10_pn = {pd_q[30:0], 1'b0};
    end else begin
      s10_pn = pd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (adv) begin
      s10_v     <= pd_v;
      s10_p     <= s10_pn;
      s10_t     <= pd_side.t;
      s10_fault <= pd_side.fault | pd_side.zero;
    end
  end

  // ------------------------------------------------- s11: correction terms
  logic [31:0] s11_a, s11_c2p;
  logic        s11_v, s11_fault;
  logic [31:0] s11_sq, s11_x2, s11_p, s11_t;

  assign s11_a   = 32'($signed(s10_p) >>> 8);
  assign s11_c2p = P_C2 * s10_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (adv) begin
      s11_v     <= s10_v;
      s11_sq    <= s11_a * s11_a;
      s11_x2    <= 32'($signed(s11_c2p) >>> 16);
      s11_p     <= s10_p;
      s11_t     <= s10_t;
      s11_fault <= s10_fault;
    end
  end

  // ----------------------------------------------------------- s12: x1
  logic [31:0] s12_prod;
  logic        s12_v, s12_fault;
  logic [31:0] s12_x1, s12_x2, s12_p, s12_t;

  assign s12_prod = s11_sq * P_C1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_v <= 1'b0;
    end else if (adv) begin
      s12_v     <= s11_v;
      s12_x1    <= 32'($signed(s12_prod) >>> 16);
      s12_x2    <= s11_x2;
      s12_p     <= s11_p;
      s12_t     <= s11_t;
      s12_fault <= s11_fault;
    end
  end

  // ----------------------------------------------------------- s13: out
  logic [31:0] s13_sum, s13_corr;

  assign s13_sum  = s12_x1 + s12_x2 + P_C3;
  assign s13_corr = 32'($signed(s13_sum) >>> 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid          <= s12_v;
      temperature_tenths <= s12_t;
      pressure_pa        <= s12_p + s13_corr;
      divide_fault       <= s12_fault;
    end
  end

  // ------------------------------------------------------------ checks
  a_stall_from_output : assert property (@(posedge clk)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output");

  a_reset_empties : assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_v && !s12_v))
    else $error("pipeline not empty after reset");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s1_v) && $stable(s10_v) && $stable(s12_p)))
    else $error("pipeline moved while held");

  a_zero_div_fault : assert property (@(posedge clk) disable iff (rst)
    (adv && pd_v && pd_side.zero) |=> s10_fault)
    else $error("zero pressure divisor lost its fault flag");

endmodule

FILE: design/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined unsigned 32/32 restoring divider, DIV_BITS quotient bits per
// stage, with side data that travels alongside each transaction.
// ----------------------------------------------------------------------------
module bptc_div
  import bptc_pkg::*;
#(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       num,
  input  logic [31:0]       den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [31:0]       quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld    [DIV_STAGES];
  logic [31:0]       rem_q  [DIV_STAGES];
  logic [31:0]       num_q  [DIV_STAGES];
  logic [31:0]       den_q  [DIV_STAGES];
  logic [SIDE_W-1:0] side_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic              src_vld;
    logic [31:0]       src_rem;
    logic [31:0]       src_num;
    logic [31:0]       src_den;
    logic [SIDE_W-1:0] src_side;
    logic [31:0]       rem_next;
    logic [31:0]       num_next;
    logic [32:0]       trial;

    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_num  = num;
      assign src_den  = den;
      assign src_side = side;
    end else begin : g_rest
      assign src_vld  = vld[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_num  = num_q[s-1];
      assign src_den  = den_q[s-1];
      assign src_side = side_q[s-1];
    end

    // shift in DIV_BITS dividend bits one at a time, subtract when the divisor fits
    always_comb begin
      rem_next = src_rem;
      num_next = src_num;
      trial    = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
        trial    = {rem_next, num_next[31]};
        num_next = {num_next[30:0], 1'b0};
        if (trial >= {1'b0, src_den}) begin
          trial       = trial - {1'b0, src_den};
          num_next[0] = 1'b1;
        end
        rem_next = trial[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s]    <= src_vld;
        rem_q[s]  <= rem_next;
        num_q[s]  <= num_next;
        den_q[s]  <= src_den;
        side_q[s] <= src_side;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quo       = num_q[DIV_STAGES-1];
  assign out_side  = side_q[DIV_STAGES-1];

endmodule
